// ===== rtl/olst_pkg.sv =====
// Types and codes shared by the ordered list store.
// Used by olst_cell and ordered_list_store; depends on nothing else.
`timescale 1ns / 1ps

package olst_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_DEL_POS = 3'd1,
    CMD_DEL_KEY = 3'd2,
    CMD_SEARCH  = 3'd3,
    CMD_READ    = 3'd4,
    CMD_COUNT   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOKEY  = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         found_position;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic cmp_en;     // register compare of the held entry against the key
    logic load;       // take the new value
    logic from_left;  // take the left neighbor's entry (insert shift)
    logic from_right; // take the right neighbor's entry (delete shift)
  } cell_ctl_t;

endpackage

// ===== rtl/olst_cell.sv =====
// One storage cell of the ordered list store: holds one entry and its key match.
// Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_cell (
  input  logic                clk_i,
  input  olst_pkg::cell_ctl_t ctl_i,
  input  logic signed [31:0]  new_i,
  input  logic signed [31:0]  left_i,
  input  logic signed [31:0]  right_i,
  input  logic signed [31:0]  key_i,
  output logic signed [31:0]  value_o,
  output logic                match_o
);

  logic signed [31:0] value_q;
  logic               match_q;

  always_ff @(posedge clk_i) begin
    priority if (ctl_i.load) begin
      value_q <= new_i;
    end else if (ctl_i.from_left) begin
      value_q <= left_i;
    end else if (ctl_i.from_right) begin
      value_q <= right_i;
    end else begin
      value_q <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      match_q <= (value_q == key_i);
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ===== rtl/ordered_list_store.sv =====
// Top level of the ordered list store: a row of olst_cell entries and the
// command sequencer. Depends on olst_pkg and olst_cell.
`timescale 1ns / 1ps

// On the accepting edge of a request each cell registers its key compare, and
// in the execute state the first match, the read select and the one-place
// shift of the cell row are resolved and the row updates. busy_o is high
// during the execute state only; the result appears for one
// cycle with done_o in the cycle after, while the next request may already be
// accepted. The receiver cannot stall, so done_o must be sampled when it is
// high. Entries shift toward the tail on insert and toward the head on delete.
module ordered_list_store #(
  parameter int DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  olst_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             done_o,
  output olst_pkg::rsp_t   rsp_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW + 1 > 7) ? CW + 1 : 7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e               state_q, state_d;
  olst_pkg::req_t       req_q;
  logic [CW-1:0]        count_q, count_d;
  olst_pkg::rsp_t       rsp_q, rsp_d;
  logic                 done_q;

  olst_pkg::cell_ctl_t  ctl     [DEPTH];
  logic signed [31:0]   cell_val[DEPTH];
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     hit;
  logic [DEPTH-1:0]     hit_pre;
  logic [DEPTH-1:0]     first_hit;
  logic [DEPTH-1:0]     sel;
  logic [DEPTH-1:0]     in_use;

  logic                 accept;
  logic                 exec;
  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        pos_m1;
  logic [PW-1:0]        cnt_w;
  logic [IW-1:0]        hit_idx;
  logic                 found;
  logic signed [31:0]   rd_val;
  logic                 do_ins;
  logic                 do_del_pos;
  logic                 do_del_key;
  logic                 pos_ok_ins;
  logic                 pos_ok_any;

  assign accept = start_i && (state_q == ST_IDLE);
  assign exec   = (state_q == ST_EXEC);

  assign pos_w  = PW'(req_q.position);
  assign pos_m1 = pos_w - PW'(1);
  assign cnt_w  = PW'(count_q);

  assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign pos_ok_any = (pos_w != '0) && (pos_w <= cnt_w);

  // Cell row with per-cell match, select and occupancy flags.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_v;
    logic signed [31:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = cell_val[i];
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    assign in_use[i] = (CW'(i) < count_q);
    assign hit[i]    = match[i] && in_use[i];
    assign sel[i]    = (pos_m1 == PW'(i));

    if (i == 0) begin : g_pre0
      assign hit_pre[i]   = hit[i];
      assign first_hit[i] = hit[i];
    end else begin : g_pre
      assign hit_pre[i]   = hit_pre[i-1] | hit[i];
      assign first_hit[i] = hit[i] & ~hit_pre[i-1];
    end

    always_comb begin
      ctl[i].cmp_en     = accept;
      ctl[i].load       = do_ins && sel[i];
      ctl[i].from_left  = do_ins && (PW'(i) > pos_m1);
      ctl[i].from_right = (do_del_pos && (PW'(i) >= pos_m1)) ||
                          (do_del_key && hit_pre[i]);
    end

    olst_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[i]),
      .new_i   (req_q.value),
      .left_i  (left_v),
      .right_i (right_v),
      .key_i   (req_i.value),
      .value_o (cell_val[i]),
      .match_o (match[i])
    );
  end

  assign found = hit_pre[DEPTH-1];

  // Index of the first match and the selected entry, as OR of one-hot terms.
  always_comb begin
    hit_idx = '0;
    rd_val  = '0;
    for (int j = 0; j < DEPTH; j++) begin
      hit_idx = hit_idx | (first_hit[j] ? IW'(j) : '0);
      rd_val  = rd_val | ((sel[j] && in_use[j]) ? cell_val[j] : '0);
    end
  end

  always_comb begin
    do_ins     = 1'b0;
    do_del_pos = 1'b0;
    do_del_key = 1'b0;
    count_d    = count_q;
    rsp_d      = '0;
    rsp_d.status = olst_pkg::STAT_OK;

    unique case (olst_pkg::cmd_e'(req_q.cmd))
      olst_pkg::CMD_INSERT: begin
        if (count_q == CW'(DEPTH)) begin
          rsp_d.status = olst_pkg::STAT_FULL;
        end else if (!pos_ok_ins) begin
          rsp_d.status = olst_pkg::STAT_RANGE;
        end else begin
          do_ins  = exec;
          count_d = count_q + CW'(1);
        end
      end
      olst_pkg::CMD_DEL_POS: begin
        if (!pos_ok_any) begin
          rsp_d.status = olst_pkg::STAT_RANGE;
        end else begin
          do_del_pos = exec;
          count_d    = count_q - CW'(1);
        end
      end
      olst_pkg::CMD_DEL_KEY, olst_pkg::CMD_SEARCH: begin
        if (!found) begin
          rsp_d.status = olst_pkg::STAT_NOKEY;
        end else if (olst_pkg::cmd_e'(req_q.cmd) == olst_pkg::CMD_DEL_KEY) begin
          do_del_key = exec;
          count_d    = count_q - CW'(1);
        end
      end
      olst_pkg::CMD_READ: begin
        if (!pos_ok_any) begin
          rsp_d.status = olst_pkg::STAT_RANGE;
        end else begin
          rsp_d.read_value = rd_val;
        end
      end
      default: begin
        rsp_d.status = olst_pkg::STAT_OK;
      end
    endcase

    // Key commands that find their key report the match place, all others the slot past the tail.
    if (((olst_pkg::cmd_e'(req_q.cmd) == olst_pkg::CMD_DEL_KEY) ||
         (olst_pkg::cmd_e'(req_q.cmd) == olst_pkg::CMD_SEARCH)) && found) begin
      rsp_d.found_position = 7'(PW'(hit_idx) + PW'(1));
    end else begin
      rsp_d.found_position = 7'(PW'(count_d) + PW'(1));
    end
    rsp_d.entry_count = 7'(PW'(count_d));
    rsp_d.is_empty    = (count_d == '0);
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
